>>> rtl/core/q16a_pkg.sv
// Shared types, constants and the rounding multiply helper for the Q16.16 atan2 block.
`timescale 1ns / 1ps

package q16a_pkg;

   typedef logic [31:0]        word_type;
   typedef logic signed [31:0] sword_type;
   typedef logic signed [63:0] prod_type;

   localparam word_type OVERFLOW_WORD        = 32'h8000_0000;
   localparam word_type COEF_CUBIC           = 32'h0000_3240;
   localparam word_type COEF_LINEAR          = 32'h0000_FB50;
   localparam word_type OFFSET_QUARTER       = 32'h0000_C90F;
   localparam word_type OFFSET_THREE_QUARTER = 32'h0002_5B2F;

   localparam prod_type ROUND_POS = 64'sh0000_0000_0000_8000;
   localparam prod_type ROUND_NEG = 64'sh0000_0000_0000_7FFF;

   // Quotient bits produced by the serial divider, one per cycle.
   localparam int unsigned DIV_STEPS = 32;
   localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

   // Operand pairs for the shared multiplier, in the order they are used.
   typedef enum logic [1:0] {
      MSEL_RR = 2'd0,   // ratio * ratio
      MSEL_R3 = 2'd1,   // ratio^2 * ratio
      MSEL_C3 = 2'd2,   // cubic coefficient * ratio^3
      MSEL_C1 = 2'd3    // linear coefficient * ratio
   } mul_sel_type;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b0_0000_0001,
      ST_FORM  = 9'b0_0000_0010,
      ST_SETUP = 9'b0_0000_0100,
      ST_DIV   = 9'b0_0000_1000,
      ST_ROUND = 9'b0_0001_0000,
      ST_MUL   = 9'b0_0010_0000,
      ST_RND   = 9'b0_0100_0000,
      ST_SUM   = 9'b0_1000_0000,
      ST_DONE  = 9'b1_0000_0000
   } state_type;

   typedef struct packed {
      logic        load_in;
      logic        form;
      logic        setup;
      logic        div_step;
      logic        round;
      logic        mul;
      logic        rnd;
      logic        sum;
      logic        out_load;
      mul_sel_type mul_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic div_last;
   } dp_status_type;

   // Q16.16 product rounding: 0x80000000 outside [-2^47, 2^47), ties away from zero.
   function automatic word_type mul_round(input prod_type prod);
      prod_type adj;
      logic     in_range;
      in_range = (prod[63:47] == {17{prod[63]}});
      adj      = prod + (prod[63] ? ROUND_NEG : ROUND_POS);
      return in_range ? adj[47:16] : OVERFLOW_WORD;
   endfunction

endpackage

>>> rtl/core/q16a_stream_if.sv
// Valid/ready stream interfaces for the request and response channels.
`timescale 1ns / 1ps

interface q16a_req_if;
   logic                 valid;
   logic                 ready;
   q16a_pkg::sword_type  y_value;
   q16a_pkg::sword_type  x_value;

   modport source (output valid, y_value, x_value, input ready);
   modport sink   (input valid, y_value, x_value, output ready);
endinterface

interface q16a_rsp_if;
   logic                 valid;
   logic                 ready;
   q16a_pkg::sword_type  angle;

   modport source (output valid, angle, input ready);
   modport sink   (input valid, angle, output ready);
endinterface

>>> rtl/core/q16a_datapath.sv
// Datapath: ratio forming, serial restoring divider, shared multiplier and polynomial sum.
`timescale 1ns / 1ps

module q16a_datapath (
   input  logic                    clock,
   input  q16a_pkg::sword_type     in_y,
   input  q16a_pkg::sword_type     in_x,
   input  q16a_pkg::dp_cmd_type    cmd,
   output q16a_pkg::dp_status_type status,
   output q16a_pkg::sword_type     out_angle
);
   import q16a_pkg::*;

   word_type        y_ff, x_ff;
   word_type        num_ff, den_ff;
   word_type        rem_ff, quo_ff, dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic            qneg_ff, special_ff;
   word_type        ratio_ff;
   prod_type        prod_ff;
   word_type        sq_ff, r3_ff, term3_ff, term1_ff;
   word_type        angle_ff, out_ff;

   word_type        ay, num_in, den_in;
   word_type        mag_num, mag_den;
   logic            ovf;
   logic [32:0]     trial, diff;
   logic            fits;
   word_type        rem_in, quo_in;
   logic [CNT_W-1:0] cnt_in;
   logic            round_up;
   word_type        quo_rnd, ratio_in;
   sword_type       op_a, op_b;
   prod_type        prod_in;
   word_type        rounded;
   word_type        poly, angle_in;

   always_comb begin
      // Ratio operands: numerator and denominator as wrapping 32-bit sums.
      ay     = y_ff[31] ? (32'd0 - y_ff) : y_ff;
      num_in = x_ff[31] ? (x_ff + ay) : (x_ff - ay);
      den_in = x_ff[31] ? (ay - x_ff) : (x_ff + ay);

      mag_num = num_ff[31] ? (32'd0 - num_ff) : num_ff;
      mag_den = den_ff[31] ? (32'd0 - den_ff) : den_ff;
      // Quotient above 2^15 does not fit the Q16.16 result.
      ovf     = {15'd0, mag_num} > {mag_den, 15'd0};

      // One restoring step: shift the next dividend bit into the remainder.
      trial  = {rem_ff, quo_ff[31]};
      diff   = trial - {1'b0, dvs_ff};
      fits   = (trial >= {1'b0, dvs_ff});
      rem_in = fits ? diff[31:0] : trial[31:0];
      quo_in = {quo_ff[30:0], fits};
      cnt_in = cnt_ff + 1'b1;

      // Round half up on the last bit, then restore the sign.
      round_up = ({rem_ff, 1'b0} >= {1'b0, dvs_ff});
      quo_rnd  = quo_ff + {31'd0, round_up};
      if (special_ff) begin
         ratio_in = OVERFLOW_WORD;
      end else if (qneg_ff) begin
         ratio_in = 32'd0 - quo_rnd;
      end else begin
         ratio_in = quo_rnd;
      end

      case (cmd.mul_sel)
         MSEL_RR: begin
            op_a = ratio_ff;
            op_b = ratio_ff;
         end
         MSEL_R3: begin
            op_a = sq_ff;
            op_b = ratio_ff;
         end
         MSEL_C3: begin
            op_a = COEF_CUBIC;
            op_b = r3_ff;
         end
         MSEL_C1: begin
            op_a = COEF_LINEAR;
            op_b = ratio_ff;
         end
         default: begin
            op_a = ratio_ff;
            op_b = ratio_ff;
         end
      endcase
      prod_in = op_a * op_b;
      rounded = mul_round(prod_ff);

      poly     = term3_ff - term1_ff + (x_ff[31] ? OFFSET_THREE_QUARTER : OFFSET_QUARTER);
      angle_in = y_ff[31] ? (32'd0 - poly) : poly;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         y_ff <= word_type'(in_y);
         x_ff <= word_type'(in_x);
      end
      if (cmd.form) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
      if (cmd.setup) begin
         rem_ff     <= {16'd0, mag_num[31:16]};
         quo_ff     <= {mag_num[15:0], 16'd0};
         dvs_ff     <= mag_den;
         cnt_ff     <= '0;
         qneg_ff    <= num_ff[31] ^ den_ff[31];
         special_ff <= (den_ff == 32'd0) || ovf;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_in;
      end
      if (cmd.round) begin
         ratio_ff <= ratio_in;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.rnd) begin
         case (cmd.mul_sel)
            MSEL_RR: sq_ff    <= rounded;
            MSEL_R3: r3_ff    <= rounded;
            MSEL_C3: term3_ff <= rounded;
            MSEL_C1: term1_ff <= rounded;
            default: sq_ff    <= rounded;
         endcase
      end
      if (cmd.sum) begin
         angle_ff <= angle_in;
      end
      if (cmd.out_load) begin
         out_ff <= angle_ff;
      end
   end

   assign status.div_last = (cnt_ff == CNT_W'(DIV_STEPS - 1));
   assign out_angle       = sword_type'(out_ff);

endmodule

>>> rtl/core/q16a_control.sv
// Controller: sequences one item through divide, multiply and sum, and owns both handshakes.
`timescale 1ns / 1ps

module q16a_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  q16a_pkg::dp_status_type status,
   output q16a_pkg::dp_cmd_type    cmd
);
   import q16a_pkg::*;

   state_type   state_ff, state_in;
   mul_sel_type step_ff, step_in;
   logic        out_valid_ff, out_valid_in;
   logic        accept;
   logic        out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.mul_sel = step_ff;

      case (state_ff)
         ST_IDLE: begin
            cmd.load_in = accept;
            if (accept) begin
               state_in = ST_FORM;
            end
         end
         ST_FORM: begin
            cmd.form = 1'b1;
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            step_in   = MSEL_RR;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_RND;
         end
         ST_RND: begin
            cmd.rnd = 1'b1;
            case (step_ff)
               MSEL_RR: step_in = MSEL_R3;
               MSEL_R3: step_in = MSEL_C3;
               MSEL_C3: step_in = MSEL_C1;
               default: step_in = MSEL_C1;
            endcase
            state_in = (step_ff == MSEL_C1) ? ST_SUM : ST_MUL;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the output register is free.
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= MSEL_RR;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

>>> rtl/core/q16_fixed_point_atan2.sv
// Q16.16 four-quadrant arctangent. Each request transfer carries a signed Q16.16
// pair (y_value, x_value); each response transfer returns one signed Q16.16 angle in
// radians. The angle comes from the ratio (x-|y|)/(x+|y|) for x >= 0, or
// (x+|y|)/(|y|-x) otherwise, fed to the cubic 0x3240*r^3 - 0xFB50*r plus pi/4 or
// 3pi/4, and negated for negative y. A zero divisor, or a ratio too large for Q16.16,
// yields the ratio 0x80000000, and every multiply rounds to nearest and returns
// 0x80000000 on overflow; all sums wrap. One item is in flight at a time: a new
// request is taken only once the previous angle has moved into the output register.
// Each item passes the restoring divider, which yields 32 quotient bits, one per
// cycle, and a single multiplier that is used four times, each use going through
// the product register, then rounding. The response sits in an output register, so
// the next request is accepted while a finished angle still waits for its transfer;
// the block stalls only if that angle is still unclaimed when the next one is done.
// Reset is synchronous and active high.
`timescale 1ns / 1ps

module q16_fixed_point_atan2 (
   input logic         clock,
   input logic         reset,
   q16a_req_if.sink    req_if,
   q16a_rsp_if.source  rsp_if
);
   import q16a_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer: owns both handshakes and steps the datapath.
   q16a_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic: operands are captured on the request transfer, the angle is
   // held in the output register until the response transfer.
   q16a_datapath u_datapath (
      .clock     (clock),
      .in_y      (req_if.y_value),
      .in_x      (req_if.x_value),
      .cmd       (cmd),
      .status    (status),
      .out_angle (rsp_if.angle)
   );

endmodule

>>> rtl/core/q16a_checker.sv
// Port-level checks for the atan2 block, bound to the top level.
`timescale 1ns / 1ps

module q16a_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input q16a_pkg::sword_type rsp_angle
);

   // One item at a time: a request transfer closes the request side next cycle.
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while an item is in progress");

   // Leaving reset: no response pending and ready for a request.
   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("bad state after reset");

   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped before transfer");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_angle))
      else $error("response angle changed while stalled");

endmodule

bind q16_fixed_point_atan2 q16a_checker u_q16a_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_angle (rsp_if.angle)
);

>>> test/q16_fixed_point_atan2_tb.sv
// Self-checking testbench for the Q16.16 four-quadrant arctangent block.
`timescale 1ns / 1ps

module q16_fixed_point_atan2_tb;
   import q16a_pkg::*;

   localparam int unsigned RESET_CYCLES = 7;
   localparam int unsigned IDLE_MAX     = 17;
   // Long enough for the output register and the datapath to fill and stall the input.
   localparam int unsigned HOLD_CYCLES  = 400;
   // Covers the block latency from request to response; leave some margin.
   localparam int unsigned TAIL_CYCLES  = 60;
   // Slowest correct run is near 1300 items plus the holds; allow far more.
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;

   localparam prod_type PRODUCT_LIMIT = 64'sh0000_8000_0000_0000;
   localparam word_type QUOTIENT_ONE  = 32'h0001_0000;

   logic clock;
   logic reset;

   q16a_req_if req_bus ();
   q16a_rsp_if rsp_bus ();

   q16_fixed_point_atan2 u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // Angles predicted for accepted requests, oldest first.
   word_type    angle_queue[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   bit          reset_done     = 1'b0;
   bit          tx_idle_on     = 1'b1;
   bit          rx_idle_on     = 1'b1;
   bit          hold_request   = 1'b0;

   // ------------------------------------------------------------------
   // Angle predictor
   // ------------------------------------------------------------------

   // Q16.16 multiply: 0x80000000 outside [-2^47, 2^47), round ties away from zero.
   function automatic word_type q16_product(input word_type a, input word_type b);
      sword_type sa;
      sword_type sb;
      prod_type  full;
      prod_type  biased;
      sa   = a;
      sb   = b;
      full = prod_type'(sa) * prod_type'(sb);
      if (full >= PRODUCT_LIMIT || full < -PRODUCT_LIMIT)
         return OVERFLOW_WORD;
      if (full < 0)
         biased = full + ROUND_NEG;
      else
         biased = full + ROUND_POS;
      // Floor division by 2^16, keep the low word (a round-up to 2^31 wraps).
      return biased[47:16];
   endfunction

   // Restoring Q16.16 divide with the last quotient bit rounded.
   function automatic word_type q16_quotient(input word_type num, input word_type den);
      word_type rem;
      word_type dvs;
      word_type quo;
      word_type qbit;
      if (den == '0)
         return OVERFLOW_WORD;
      rem  = num[31] ? (32'd0 - num) : num;
      dvs  = den[31] ? (32'd0 - den) : den;
      quo  = '0;
      qbit = QUOTIENT_ONE;
      // Align the divider under the dividend.
      while (dvs < rem) begin
         dvs  = dvs << 1;
         qbit = qbit << 1;
      end
      if (qbit == '0)
         return OVERFLOW_WORD;
      // A divider in bit 31 cannot be shifted further; take one step by shifting it down.
      if (dvs[31]) begin
         if (rem >= dvs) begin
            quo = quo | qbit;
            rem = rem - dvs;
         end
         dvs  = dvs >> 1;
         qbit = qbit >> 1;
      end
      while (qbit != '0 && rem != '0) begin
         if (rem >= dvs) begin
            quo = quo | qbit;
            rem = rem - dvs;
         end
         rem  = rem << 1;
         qbit = qbit >> 1;
      end
      if (rem >= dvs)
         quo = quo + 32'd1;
      if (num[31] ^ den[31]) begin
         if (quo == OVERFLOW_WORD)
            return OVERFLOW_WORD;
         quo = 32'd0 - quo;
      end
      return quo;
   endfunction

   function automatic word_type predict_angle(input sword_type y, input sword_type x);
      word_type yw;
      word_type xw;
      word_type mag_y;
      word_type ratio;
      word_type ratio_cubed;
      word_type offset;
      word_type angle;
      yw    = y;
      xw    = x;
      mag_y = yw[31] ? (32'd0 - yw) : yw;
      if (!xw[31]) begin
         ratio  = q16_quotient(xw - mag_y, xw + mag_y);
         offset = OFFSET_QUARTER;
      end else begin
         ratio  = q16_quotient(xw + mag_y, mag_y - xw);
         offset = OFFSET_THREE_QUARTER;
      end
      ratio_cubed = q16_product(q16_product(ratio, ratio), ratio);
      angle = q16_product(COEF_CUBIC, ratio_cubed) - q16_product(COEF_LINEAR, ratio) + offset;
      if (yw[31])
         angle = 32'd0 - angle;
      return angle;
   endfunction

   // ------------------------------------------------------------------
   // Clock, reset and watchdog
   // ------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Stop a hung run; a correct run finishes far below this count.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Response side: random stalls, optional long hold, in-order check
   // ------------------------------------------------------------------

   initial begin : angle_checker
      int unsigned stall;
      word_type    expected;
      rsp_bus.ready <= 1'b0;
      wait (reset_done);
      forever begin
         stall = rx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
         // Hold off for a long stretch when asked, so the block backs up into its input.
         if (hold_request) begin
            stall        = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         // Ready is high at every edge below, so valid alone marks the transfer.
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         if (angle_queue.size() == 0) begin
            $display("%0t: unexpected angle transfer, expected none, actual %h",
                     $time, rsp_bus.angle);
            mismatch_count++;
         end else begin
            expected = angle_queue.pop_front();
            if (rsp_bus.angle !== expected) begin
               $display("%0t: angle mismatch, expected %h, actual %h",
                        $time, expected, rsp_bus.angle);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side helpers
   // ------------------------------------------------------------------

   // Offer one (y, x) pair, after a random gap if idling is on, and record its angle on transfer.
   task automatic send_pair(input sword_type y, input sword_type x);
      int unsigned gap;
      gap = tx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      // Keep valid high across back-to-back pairs; only the payload changes.
      req_bus.valid   <= 1'b1;
      req_bus.y_value <= y;
      req_bus.x_value <= x;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      angle_queue.push_back(predict_angle(y, x));
   endtask

   // Drop valid and wait until every predicted angle has come back.
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (angle_queue.size() != 0);
   endtask

   // Mix of full-range words, small Q16.16 values, words near the extremes, zero and one, and
   // words of varied magnitude, so every bit toggles and the divider sees all spans.
   function automatic sword_type random_operand();
      sword_type v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom;
         4, 5, 6: begin
            v = $urandom_range(0, 32'h0020_0000);
            v = v - 32'sh0010_0000;
         end
         7: begin
            case ($urandom_range(0, 3))
               0: v = 32'sh8000_0000;
               1: v = 32'sh7FFF_FFFF;
               2: v = '0;
               default: v = 32'sh0001_0000;
            endcase
            v = v + sword_type'($urandom_range(0, 2)) - 32'sd1;
         end
         default: begin
            v = $urandom;
            v = v >>> $urandom_range(0, 31);
         end
      endcase
      return v;
   endfunction

   task automatic send_random_pairs(input int unsigned count);
      sword_type y;
      sword_type x;
      repeat (count) begin
         y = random_operand();
         x = random_operand();
         // Tie x to y now and then: ratios near zero, zero divisors, equal magnitudes.
         if ($urandom_range(0, 7) == 0) begin
            x = $urandom_range(0, 1) ? y : -y;
            x = x + sword_type'($urandom_range(0, 2)) - 32'sd1;
         end
         send_pair(y, x);
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Field extremes, every quadrant and the special cases of the datapath.
   task automatic test_directed();
      send_pair(32'sh0000_0000, 32'sh0000_0000);   // zero divisor at the origin
      send_pair(32'sh0000_0000, 32'sh0001_0000);   // positive x axis
      send_pair(32'sh0001_0000, 32'sh0000_0000);   // positive y axis
      send_pair(32'shFFFF_0000, 32'sh0000_0000);   // negative y axis
      send_pair(32'sh0000_0000, 32'shFFFF_0000);   // negative x axis
      send_pair(32'sh0001_0000, 32'sh0001_0000);   // first quadrant diagonal
      send_pair(32'sh0001_0000, 32'shFFFF_0000);   // second quadrant diagonal
      send_pair(32'shFFFF_0000, 32'shFFFF_0000);   // third quadrant diagonal
      send_pair(32'shFFFF_0000, 32'sh0001_0000);   // fourth quadrant diagonal
      send_pair(32'sh0000_0001, 32'sh0000_0000);
      send_pair(32'sh0000_0000, 32'shFFFF_FFFF);
      send_pair(32'shFFFF_FFFF, 32'shFFFF_FFFF);
      // Most negative y keeps magnitude 0x80000000.
      send_pair(32'sh8000_0000, 32'sh0000_0000);
      send_pair(32'sh8000_0000, 32'sh7FFF_FFFF);
      send_pair(32'sh8000_0000, 32'sh4000_0000);
      // Both at the most negative word: |y| - x wraps to a zero divisor.
      send_pair(32'sh8000_0000, 32'sh8000_0000);
      send_pair(32'sh8000_0000, 32'sh8000_0001);
      // Sums that wrap past the word.
      send_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_pair(32'sh7FFF_FFF0, 32'sh7FFF_FFFF);
      send_pair(32'sh7FFF_FFFF, 32'sh8000_0000);
      send_pair(32'sh8000_0001, 32'sh8000_0000);
      send_pair(32'sh0000_0002, 32'sh7FFF_FFFF);
      send_pair(32'sh7FFF_FFFF, 32'sh0000_0001);
      send_pair(32'sh0000_0003, 32'shFFFF_FFFD);
   endtask

   task automatic test_random_idle(input int unsigned count);
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      send_random_pairs(count);
   endtask

   // A stretch with no idling on either side.
   task automatic test_full_rate(input int unsigned count);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      send_random_pairs(count);
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   // Receiver holds off while the sender keeps offering, so the input stalls.
   task automatic test_output_hold();
      tx_idle_on   = 1'b0;
      hold_request = 1'b1;
      send_random_pairs(16);
      tx_idle_on   = 1'b1;
   endtask

   // Sender pauses until every angle is back, then resumes on an idle block.
   task automatic test_drain_pause();
      send_random_pairs(20);
      wait_for_drain();
      send_random_pairs(20);
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.y_value <= '0;
      req_bus.x_value <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset      <= 1'b0;
      reset_done  = 1'b1;

      test_directed();
      test_random_idle(500);
      test_full_rate(250);
      test_output_hold();
      test_drain_pause();
      test_random_idle(470);

      // Let the last angles arrive, then give the block its latency to show strays.
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> q16_fixed_point_atan2.f
rtl/core/q16a_pkg.sv
rtl/core/q16a_stream_if.sv
rtl/core/q16a_datapath.sv
rtl/core/q16a_control.sv
rtl/core/q16_fixed_point_atan2.sv
rtl/core/q16a_checker.sv
test/q16_fixed_point_atan2_tb.sv
